FILE: design/npcq_pkg.sv
// ----------------------------------------------------------------------------
// npcq_pkg
// Shared types, palette tables and widths of the nearest palette color
// quantizer.
// ----------------------------------------------------------------------------
package npcq_pkg;

	localparam int COLOUR_COUNT  = 16;
	localparam int GROUP_COUNT   = 4;
	localparam int PALETTE_SLOTS = 16;
	localparam int IDX_W         = 4;
	localparam int POS_W         = 5;
	localparam int DIST_W        = 10;
	localparam int GRP_W         = 2;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pixel_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [3:0] palette_position;
	} result_t;

	typedef struct packed {
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [GRP_W-1:0] grp;
	} colour_t;

	// one palette entry under comparison
	typedef struct packed {
		logic              valid;
		logic [DIST_W-1:0] distance;
		logic [IDX_W-1:0]  idx;
		logic [3:0]        pos;
	} cand_t;

	// group order: frost, polar night, snow storm, aurora
	localparam colour_t COLOUR_TABLE [COLOUR_COUNT] = '{
		'{8'd143, 8'd188, 8'd187, 2'd0}, '{8'd136, 8'd192, 8'd208, 2'd0},
		'{8'd129, 8'd161, 8'd193, 2'd0}, '{8'd94,  8'd129, 8'd172, 2'd0},
		'{8'd46,  8'd52,  8'd64,  2'd1}, '{8'd59,  8'd66,  8'd82,  2'd1},
		'{8'd67,  8'd76,  8'd94,  2'd1}, '{8'd76,  8'd86,  8'd106, 2'd1},
		'{8'd216, 8'd222, 8'd233, 2'd2}, '{8'd229, 8'd233, 8'd240, 2'd2},
		'{8'd236, 8'd239, 8'd244, 2'd2},
		'{8'd191, 8'd97,  8'd106, 2'd3}, '{8'd208, 8'd135, 8'd112, 2'd3},
		'{8'd235, 8'd203, 8'd139, 2'd3}, '{8'd163, 8'd190, 8'd140, 2'd3},
		'{8'd180, 8'd142, 8'd173, 2'd3}
	};

	localparam logic [POS_W-1:0] GROUP_START [GROUP_COUNT] = '{5'd0, 5'd4, 5'd8, 5'd11};
	localparam logic [POS_W-1:0] GROUP_SIZE  [GROUP_COUNT] = '{5'd4, 5'd4, 5'd3, 5'd5};

endpackage

FILE: design/npcq_reduce4.sv
// ----------------------------------------------------------------------------
// npcq_reduce4
// Picks the nearest of four candidates; on equal distance the lower slot wins.
// ----------------------------------------------------------------------------
module npcq_reduce4 (
	input  npcq_pkg::cand_t cand [4],
	output npcq_pkg::cand_t best
);

	npcq_pkg::cand_t lo;
	npcq_pkg::cand_t hi;

	function automatic npcq_pkg::cand_t pick(input npcq_pkg::cand_t a,
			input npcq_pkg::cand_t b);
		if (b.valid && (!a.valid || (b.distance < a.distance))) begin
			return b;
		end
		return a;
	endfunction

	always_comb begin
		lo   = pick(cand[0], cand[1]);
		hi   = pick(cand[2], cand[3]);
		best = pick(lo, hi);
	end

endmodule

FILE: design/nearest_palette_color_quantizer.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_quantizer
// Maps an RGB888 pixel to the nearest color (L1 distance) of a palette
// packed from the enabled constant color groups.
// ----------------------------------------------------------------------------
// Usage:
//   pix_valid/pix_stall/pix carry pixel requests in; res_valid/res_stall/res
//   carry the chosen color and its packed palette position out. A request
//   is taken at an edge with valid high and stall low.
//   cfg_wen/cfg_wdata write group_mask (bit0 frost, bit1 polar night,
//   bit2 snow storm, bit3 aurora); write only while the block is idle.
//   res_valid rises once an accepted request has passed stage 1, stage 2 and
//   stage 3; throughput is one pixel per cycle while res_stall is low. Stage 1 computes
//   all 16 distances, stage 2 reduces them to four, stage 3 picks the
//   winner into the output register.
//   No group enabled gives black at position 0.
//   Reset empties the pipeline and sets group_mask to all groups enabled.
//   When res_stall is high the output holds; bubbles in the pipeline are
//   still filled, and pix_stall rises once every stage is occupied.
// ----------------------------------------------------------------------------
module nearest_palette_color_quantizer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [3:0]        cfg_wdata,
	input  logic              pix_valid,
	output logic              pix_stall,
	input  npcq_pkg::pixel_t  pix,
	output logic              res_valid,
	input  logic              res_stall,
	output npcq_pkg::result_t res
);

	logic [3:0] mask_q;

	logic valid_s1, valid_s2, valid_s3;
	logic adv1, adv2, adv3;

	npcq_pkg::cand_t cand_c  [npcq_pkg::COLOUR_COUNT];
	npcq_pkg::cand_t cand_s1 [npcq_pkg::COLOUR_COUNT];
	npcq_pkg::cand_t part_c  [4];
	npcq_pkg::cand_t part_s2 [4];
	npcq_pkg::cand_t win_c;
	npcq_pkg::result_t res_s3;

	logic [npcq_pkg::POS_W-1:0] grp_off [npcq_pkg::GROUP_COUNT];

	function automatic logic [8:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? {1'b0, a - b} : {1'b0, b - a};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 4'hF;
		end else if (cfg_wen) begin
			mask_q <= cfg_wdata;
		end
	end

	assign adv3      = !valid_s3 || !res_stall;
	assign adv2      = !valid_s2 || adv3;
	assign adv1      = !valid_s1 || adv2;
	assign pix_stall = !adv1;

	// packed start of each group
	always_comb begin
		grp_off[0] = '0;
		for (int g = 1; g < npcq_pkg::GROUP_COUNT; g++) begin
			grp_off[g] = grp_off[g-1] + (mask_q[g-1] ? npcq_pkg::GROUP_SIZE[g-1] : '0);
		end
	end

	always_comb begin
		for (int i = 0; i < npcq_pkg::COLOUR_COUNT; i++) begin
			logic [npcq_pkg::GRP_W-1:0] g;
			logic [npcq_pkg::POS_W-1:0] p;
			g = npcq_pkg::COLOUR_TABLE[i].grp;
			p = grp_off[g] + npcq_pkg::POS_W'(i) - npcq_pkg::GROUP_START[g];
			cand_c[i].valid    = mask_q[g] && (p < npcq_pkg::POS_W'(npcq_pkg::PALETTE_SLOTS));
			cand_c[i].distance =
				npcq_pkg::DIST_W'(abs_diff(pix.red_in, npcq_pkg::COLOUR_TABLE[i].red)) +
				npcq_pkg::DIST_W'(abs_diff(pix.green_in, npcq_pkg::COLOUR_TABLE[i].green)) +
				npcq_pkg::DIST_W'(abs_diff(pix.blue_in, npcq_pkg::COLOUR_TABLE[i].blue));
			cand_c[i].idx      = npcq_pkg::IDX_W'(i);
			cand_c[i].pos      = p[3:0];
		end
	end

	// stage 1: distances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && pix_valid) begin
			cand_s1 <= cand_c;
		end
	end

	// stage 2: four partial winners
	for (genvar q = 0; q < 4; q++) begin : g_part
		npcq_pkg::cand_t quad [4];
		always_comb begin
			for (int k = 0; k < 4; k++) begin
				quad[k] = cand_s1[4*q + k];
			end
		end
		npcq_reduce4 u_reduce (
			.cand (quad),
			.best (part_c[q])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			part_s2 <= part_c;
		end
	end

	// stage 3: final winner
	npcq_reduce4 u_final (
		.cand (part_s2),
		.best (win_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			if (win_c.valid) begin
				res_s3.red_out          <= npcq_pkg::COLOUR_TABLE[win_c.idx].red;
				res_s3.green_out        <= npcq_pkg::COLOUR_TABLE[win_c.idx].green;
				res_s3.blue_out         <= npcq_pkg::COLOUR_TABLE[win_c.idx].blue;
				res_s3.palette_position <= win_c.pos;
			end else begin
				res_s3 <= '0;
			end
		end
	end

	assign res_valid = valid_s3;
	assign res       = res_s3;

endmodule
